// ----- hdl/xrs_pkg.sv -----
// Shared types and constants for the xoshiro256** random source.
// Used by xrs_datapath, xrs_ctrl and xoshiro256ss_random_source.
package xrs_pkg;

  localparam logic [2:0] ACT_RAW   = 3'd0;
  localparam logic [2:0] ACT_RANGE = 3'd1;
  localparam logic [2:0] ACT_FRAC  = 3'd2;
  localparam logic [2:0] ACT_BIT   = 3'd3;
  localparam logic [2:0] ACT_BYTE  = 3'd4;
  localparam logic [2:0] ACT_SEED  = 3'd5;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

  // Partial products of a 64-bit constant multiply, low 64 bits only.
  localparam logic [1:0] MUL_LL = 2'd0;  // low x low
  localparam logic [1:0] MUL_LH = 2'd1;  // low operand x high constant, << 32
  localparam logic [1:0] MUL_HL = 2'd2;  // high operand x low constant, << 32

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture input item
    logic       seed_src;  // 1: seed from default, 0: from item
    logic       mix_init;  // load splitmix accumulator
    logic       mix_b;     // second splitmix multiply stage selected
    logic       mul_load;  // capture multiplier operand, clear product
    logic       mul_step;  // accumulate one partial product
    logic [1:0] mul_ph;    // which partial product
    logic       mix_step;  // take the finished product into the mix word
    logic       mix_store; // store mixed word into next state slot
    logic       advance;   // step xoshiro and register the output word
    logic       div_start; // start modulo
    logic       div_step;  // one restoring-division bit
    logic       finish;    // form result
    logic       clr_res;   // zero result, status set on a range error
  } xrs_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic range_err;
    logic span_zero;
  } xrs_sts_t;

endpackage

// ----- hdl/xrs_datapath.sv -----
// Datapath: state words, splitmix64 seeder with a 32x32 partial-product
// multiplier, xoshiro step, modulo unit. Depends on xrs_pkg.
module xrs_datapath (
  input  logic             clk,
  input  xrs_pkg::xrs_cmd_t cmd,
  input  logic [1:0]       slot,
  input  logic [2:0]       in_action,
  input  logic [63:0]      in_lo,
  input  logic [63:0]      in_hi,
  input  logic [63:0]      in_seed,
  input  logic [63:0]      default_seed,
  output xrs_pkg::xrs_sts_t sts,
  output logic [190:0]     res
);

  logic [63:0] w_r [4];
  logic [2:0]  act_r;
  logic [63:0] lo_r, hi_r, seed_r;
  logic [63:0] acc_r, z_r, word_r, rem_r, quo_r, span_r;
  logic [63:0] m_r, prod_r;
  logic [190:0] res_r;
  logic [63:0] mix_x, mix_c, pp, pp_add, rng;
  logic [31:0] op_a, op_b;
  logic [64:0] trial;

  assign sts.range_err = $signed(lo_r) > $signed(hi_r);
  assign sts.span_zero = (hi_r - lo_r + 64'd1) == 64'd0;
  assign res = res_r;
  assign trial = {rem_r, quo_r[63]} - {1'b0, span_r};

  // xor-shift ahead of each splitmix multiply, and the constant of that stage
  assign mix_x = cmd.mix_b ? (z_r ^ (z_r >> 27)) : (z_r ^ (z_r >> 30));
  assign mix_c = cmd.mix_b ? xrs_pkg::MIX_MUL_B : xrs_pkg::MIX_MUL_A;

  // one 32x32 partial product of the low 64 bits of m_r * mix_c per cycle
  always_comb begin
    op_a = m_r[31:0];
    op_b = mix_c[31:0];
    case (cmd.mul_ph)
      xrs_pkg::MUL_LH: op_b = mix_c[63:32];
      xrs_pkg::MUL_HL: op_a = m_r[63:32];
      default: ;
    endcase
    pp = 64'(op_a) * 64'(op_b);
    pp_add = (cmd.mul_ph == xrs_pkg::MUL_LL) ? pp : {pp[31:0], 32'd0};
  end

  // ranged value: low plus remainder, raw word on a full span
  assign rng = (act_r != xrs_pkg::ACT_RANGE) ? 64'd0 :
               sts.span_zero ? word_r : lo_r + rem_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      lo_r   <= in_lo;
      hi_r   <= in_hi;
      seed_r <= in_seed;
    end
    // start a splitmix output: acc += gamma
    if (cmd.mix_init) begin
      if (cmd.seed_src) begin
        acc_r <= default_seed + xrs_pkg::GOLDEN_GAMMA;
        z_r   <= default_seed + xrs_pkg::GOLDEN_GAMMA;
      end else begin
        acc_r <= seed_r + xrs_pkg::GOLDEN_GAMMA;
        z_r   <= seed_r + xrs_pkg::GOLDEN_GAMMA;
      end
    end
    // multi-cycle constant multiply
    if (cmd.mul_load) begin
      m_r    <= mix_x;
      prod_r <= 64'd0;
    end
    if (cmd.mul_step) begin
      prod_r <= prod_r + pp_add;
    end
    if (cmd.mix_step) begin
      z_r <= prod_r;
    end
    // finish the mix, store the word and prepare the next accumulator
    if (cmd.mix_store) begin
      w_r[slot] <= z_r ^ (z_r >> 31);
      acc_r     <= acc_r + xrs_pkg::GOLDEN_GAMMA;
      z_r       <= acc_r + xrs_pkg::GOLDEN_GAMMA;
    end
    if (cmd.advance) begin
      word_r <= xs_out(w_r[1]);
      w_r[0] <= w_r[0] ^ w_r[3] ^ w_r[1];
      w_r[1] <= w_r[1] ^ w_r[2] ^ w_r[0];
      w_r[2] <= w_r[2] ^ w_r[0] ^ (w_r[1] << 17);
      w_r[3] <= ((w_r[3] ^ w_r[1]) << 45) | ((w_r[3] ^ w_r[1]) >> 19);
    end
    if (cmd.div_start) begin
      rem_r  <= 64'd0;
      quo_r  <= word_r;
      span_r <= hi_r - lo_r + 64'd1;
    end
    // restoring division: one quotient bit per cycle
    if (cmd.div_step) begin
      if (!trial[64]) rem_r <= trial[63:0];
      else            rem_r <= {rem_r[62:0], quo_r[63]};
      quo_r <= {quo_r[62:0], ~trial[64]};
    end
    if (cmd.clr_res) begin
      res_r <= {(act_r == xrs_pkg::ACT_RANGE) && sts.range_err, 190'd0};
    end
    if (cmd.finish) begin
      res_r <= {1'b0, word_r[7:0], word_r[0], word_r[63:11], rng, word_r};
    end
  end

  // rotl(w*5, 7) * 9 via shifts and adds
  function automatic logic [63:0] xs_out(input logic [63:0] x);
    logic [63:0] a, r;
    a = x + (x << 2);
    r = (a << 7) | (a >> 57);
    return r + (r << 3);
  endfunction

endmodule

// ----- hdl/xrs_ctrl.sv -----
// Controller state machine sequencing seed, draw and modulo steps.
// Depends on xrs_pkg.
module xrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [2:0]        in_action,
  input  logic              hand_ok,
  input  xrs_pkg::xrs_sts_t sts,
  output xrs_pkg::xrs_cmd_t cmd,
  output logic [1:0]        slot,
  output logic              busy,
  output logic              res_valid
);

  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_MINIT = 4'd2, S_ML = 4'd3,
                         S_MP = 4'd4, S_MZ = 4'd5, S_MST = 4'd6, S_ADV = 4'd7,
                         S_DIVS = 4'd8, S_DIV = 4'd9, S_FIN = 4'd10, S_OUT = 4'd11;

  logic [3:0] st_r, st_nxt;
  logic [2:0] act_r, act_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic seeded_r, seeded_nxt, src_r, src_nxt, mixb_r, mixb_nxt;

  assign busy = st_r != S_IDLE;
  assign res_valid = st_r == S_OUT;
  assign slot = slot_r;

  always_comb begin
    st_nxt = st_r; act_nxt = act_r; slot_nxt = slot_r; cnt_nxt = cnt_r;
    seeded_nxt = seeded_r; src_nxt = src_r; mixb_nxt = mixb_r;
    cmd = '0;
    cmd.seed_src = src_r;
    cmd.mix_b = mixb_r;
    unique case (st_r)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1; act_nxt = in_action; st_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.clr_res = 1'b1;
        slot_nxt = 2'd0;
        if (act_r == xrs_pkg::ACT_SEED) begin
          src_nxt = 1'b0; st_nxt = S_MINIT;
        end else if (act_r > xrs_pkg::ACT_SEED ||
                     (act_r == xrs_pkg::ACT_RANGE && sts.range_err)) begin
          st_nxt = S_OUT;
        end else if (!seeded_r) begin
          src_nxt = 1'b1; st_nxt = S_MINIT;
        end else st_nxt = S_ADV;
      end
      S_MINIT: begin cmd.mix_init = 1'b1; mixb_nxt = 1'b0; st_nxt = S_ML; end
      // one splitmix multiply: load, three partial products, take result
      S_ML: begin cmd.mul_load = 1'b1; cnt_nxt = 6'd0; st_nxt = S_MP; end
      S_MP: begin
        cmd.mul_step = 1'b1; cmd.mul_ph = cnt_r[1:0]; cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[1:0] == xrs_pkg::MUL_HL) st_nxt = S_MZ;
      end
      S_MZ: begin
        cmd.mix_step = 1'b1;
        if (!mixb_r) begin
          mixb_nxt = 1'b1; st_nxt = S_ML;
        end else st_nxt = S_MST;
      end
      S_MST: begin
        cmd.mix_store = 1'b1; slot_nxt = slot_r + 2'd1; mixb_nxt = 1'b0;
        if (slot_r == 2'd3) begin
          seeded_nxt = 1'b1;
          st_nxt = (act_r == xrs_pkg::ACT_SEED) ? S_OUT : S_ADV;
        end else st_nxt = S_ML;
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        st_nxt = (act_r == xrs_pkg::ACT_RANGE) ? S_DIVS : S_FIN;
      end
      S_DIVS: begin cmd.div_start = 1'b1; cnt_nxt = 6'd63; st_nxt = S_DIV; end
      S_DIV: begin
        cmd.div_step = 1'b1; cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) st_nxt = S_FIN;
      end
      S_FIN: begin cmd.finish = 1'b1; st_nxt = S_OUT; end
      S_OUT: if (hand_ok) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; seeded_r <= 1'b0;
    end else begin
      st_r <= st_nxt; seeded_r <= seeded_nxt;
    end
    act_r <= act_nxt; slot_r <= slot_nxt; cnt_r <= cnt_nxt; src_r <= src_nxt;
    mixb_r <= mixb_nxt;
  end

  ap_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.advance && cmd.mix_store)) else $error("advance during seeding");
  ap_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> st_r == S_IDLE) else $error("accept while busy");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !hand_ok) |=> res_valid) else $error("result dropped");

endmodule

// ----- hdl/xoshiro256ss_random_source.sv -----
// Top level of the xoshiro256** random source.
// Depends on xrs_pkg, xrs_ctrl and xrs_datapath.
//
// One item is worked on at a time; the input is ready only while the core is
// idle. A plain draw steps the generator and forms the result; a ranged draw
// also runs a 64-step restoring divider that forms word mod span. A seed
// computes four splitmix64 outputs, every 64-bit constant multiply being
// three 32x32 partial products. A draw before any seed first seeds from
// default_seed. A range error or an unused action goes straight to the
// result. Each result waits in an output register, so the core can take and
// work on one more item while the receiver stalls; after that the input holds
// off.
module xoshiro256ss_random_source (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[2:0], range_low[66:3], range_high[130:67], seed_value[194:131]
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // random_word[63:0], ranged_value[127:64], fraction[180:128],
  // random_bit[181], random_byte[189:182], status[190]
  output logic [191:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data
);

  xrs_pkg::xrs_cmd_t cmd;
  xrs_pkg::xrs_sts_t sts;
  logic [1:0] slot;
  logic busy;
  logic res_valid;
  logic hand_ok;
  logic [63:0] default_seed_r;
  logic [190:0] res;
  logic [190:0] obuf_r;
  logic obuf_valid_r;

  assign in_tready = !busy;
  assign cfg_ready = 1'b1;
  assign hand_ok = !obuf_valid_r || out_tready;
  assign out_tvalid = obuf_valid_r;
  assign out_tdata = {1'b0, obuf_r};

  // hold the default seed register
  always_ff @(posedge clk) begin
    if (!rst_n) default_seed_r <= 64'd0;
    else if (cfg_valid) default_seed_r <= cfg_data;
  end

  // take the finished result into the output register, drop it on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) obuf_valid_r <= 1'b0;
    else if (res_valid && hand_ok) obuf_valid_r <= 1'b1;
    else if (out_tready) obuf_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_valid && hand_ok) obuf_r <= res;
  end

  xrs_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_tvalid && in_tready), .in_action(in_tdata[2:0]),
    .hand_ok, .sts, .cmd, .slot, .busy, .res_valid
  );

  xrs_datapath u_dp (
    .clk, .cmd, .slot, .in_action(in_tdata[2:0]), .in_lo(in_tdata[66:3]),
    .in_hi(in_tdata[130:67]), .in_seed(in_tdata[194:131]),
    .default_seed(default_seed_r), .sts, .res
  );

endmodule

// ----- test/tb_xoshiro256ss_random_source.sv -----
// Testbench for xoshiro256ss_random_source: drives draw and seed transfers,
// predicts every result with its own xoshiro256**/splitmix64 model and checks
// it field by field. Depends on xrs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_xoshiro256ss_random_source;

  localparam logic [2:0] ACT_NONE6 = 3'd6;
  localparam logic [2:0] ACT_NONE7 = 3'd7;
  localparam logic [63:0] I64_MIN = 64'h8000000000000000;
  localparam logic [63:0] I64_MAX = 64'h7fffffffffffffff;

  typedef struct packed {
    logic        status;
    logic [7:0]  random_byte;
    logic        random_bit;
    logic [52:0] fraction;
    logic [63:0] ranged_value;
    logic [63:0] random_word;
  } draw_result_t;

  // Predictor of the generator plus the queue of results still owed.
  class draw_scoreboard;
    logic [63:0]  seed_reg;
    logic [63:0]  gen_w[4];
    bit           seeded;
    draw_result_t owed[$];
    int           errors;

    function new();
      seed_reg = '0;
      seeded   = 0;
      errors   = 0;
    endfunction

    function logic [63:0] rotl(logic [63:0] x, int k);
      return (x << k) | (x >> (64 - k));
    endfunction

    function void fill_from(logic [63:0] seed);
      logic [63:0] acc, z;
      acc = seed;
      for (int i = 0; i < 4; i++) begin
        acc = acc + xrs_pkg::GOLDEN_GAMMA;
        z = acc;
        z = (z ^ (z >> 30)) * xrs_pkg::MIX_MUL_A;
        z = (z ^ (z >> 27)) * xrs_pkg::MIX_MUL_B;
        gen_w[i] = z ^ (z >> 31);
      end
      seeded = 1;
    endfunction

    function logic [63:0] step_gen();
      logic [63:0] res, t;
      res = rotl(gen_w[1] * 64'd5, 7) * 64'd9;
      t = gen_w[1] << 17;
      gen_w[2] ^= gen_w[0];
      gen_w[3] ^= gen_w[1];
      gen_w[1] ^= gen_w[2];
      gen_w[0] ^= gen_w[3];
      gen_w[2] ^= t;
      gen_w[3] = rotl(gen_w[3], 45);
      return res;
    endfunction

    // Note an accepted input transfer and queue what it should produce.
    function void note_input(logic [199:0] d);
      logic [2:0]   act;
      logic [63:0]  lo, hi, w, span;
      draw_result_t r;
      act = d[2:0];
      lo  = d[66:3];
      hi  = d[130:67];
      r   = '0;
      if (act == xrs_pkg::ACT_SEED) begin
        fill_from(d[194:131]);
      end else if (act == ACT_NONE6 || act == ACT_NONE7) begin
        r = '0;
      end else if (act == xrs_pkg::ACT_RANGE && $signed(lo) > $signed(hi)) begin
        r.status = 1'b1;
      end else begin
        if (!seeded) fill_from(seed_reg);
        w = step_gen();
        r.random_word = w;
        r.fraction    = w[63:11];
        r.random_bit  = w[0];
        r.random_byte = w[7:0];
        if (act == xrs_pkg::ACT_RANGE) begin
          span = hi - lo + 64'd1;
          r.ranged_value = (span == 0) ? w : lo + (w % span);
        end
      end
      owed.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(logic [191:0] d);
      draw_result_t g, e;
      g = d[190:0];
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (g.random_word !== e.random_word)
        $display("%0t: random_word exp %h got %h", $time, e.random_word, g.random_word);
      if (g.ranged_value !== e.ranged_value)
        $display("%0t: ranged_value exp %h got %h", $time, e.ranged_value,
                 g.ranged_value);
      if (g.fraction !== e.fraction)
        $display("%0t: fraction exp %h got %h", $time, e.fraction, g.fraction);
      if (g.random_bit !== e.random_bit)
        $display("%0t: random_bit exp %b got %b", $time, e.random_bit, g.random_bit);
      if (g.random_byte !== e.random_byte)
        $display("%0t: random_byte exp %h got %h", $time, e.random_byte, g.random_byte);
      if (g.status !== e.status)
        $display("%0t: status exp %b got %b", $time, e.status, g.status);
      if (g !== e) errors++;
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [63:0]  cfg_data;

  draw_scoreboard sb;
  int  stall_hold;   // receiver hold-off request, in cycles

  xoshiro256ss_random_source i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Sample transfers on both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Bounds biased toward edges and small spans.
  function logic [63:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return I64_MIN;
      1: return I64_MAX;
      2: return 64'($signed($urandom_range(0, 40)) - 20);
      default: return rnd64();
    endcase
  endfunction

  // Drive at the falling edge; valid drops and rises again in the same step
  // when items follow back to back.
  task automatic send_item(logic [2:0] act, logic [63:0] lo, logic [63:0] hi,
                           logic [63:0] seed, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
    repeat (gap) @(negedge clk);
    in_tdata  = {5'b0, seed, hi, lo, act};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_random(bit gaps);
    logic [2:0]  act;
    logic [63:0] lo, hi;
    int k;
    k = $urandom_range(0, 99);
    act = (k < 4) ? xrs_pkg::ACT_SEED : (k < 6) ? 3'($urandom_range(6, 7)) :
          (k < 40) ? xrs_pkg::ACT_RANGE : 3'($urandom_range(0, 4));
    lo = pick_bound();
    hi = pick_bound();
    // mostly well-ordered ranges, some inverted
    if ($urandom_range(0, 9) != 0 && $signed(lo) > $signed(hi)) begin
      lo = lo ^ hi; hi = lo ^ hi; lo = lo ^ hi;
    end
    send_item(act, lo, hi, rnd64(), gaps);
  endtask

  // Wait until nothing is owed, then let the block settle.
  task automatic drain();
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_seed(logic [63:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, with long hold-offs when asked.
  initial begin
    int w;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        out_tready <= 1'b0;
        repeat (stall_hold) @(negedge clk);
        stall_hold = 0;
      end
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    stall_hold = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: draw before any seed uses the reset default seed of zero.
    send_item(xrs_pkg::ACT_RAW, '0, '0, '0, 0);
    drain();
    write_seed(64'hffffffffffffffff); sb.seed_reg = 64'hffffffffffffffff;
    // still seeded from before, so the new default stays unused
    send_item(xrs_pkg::ACT_FRAC, '0, '0, '0, 0);
    send_item(xrs_pkg::ACT_BIT, '0, '0, '0, 0);
    send_item(xrs_pkg::ACT_BYTE, '0, '0, '0, 0);
    send_item(xrs_pkg::ACT_RANGE, I64_MIN, I64_MAX, '0, 0);     // full span
    send_item(xrs_pkg::ACT_RANGE, I64_MAX, I64_MIN, '0, 0);     // inverted range
    send_item(xrs_pkg::ACT_RANGE, 64'd5, 64'd5, '0, 0);          // single value
    send_item(xrs_pkg::ACT_RANGE, I64_MIN, I64_MIN, '0, 0);
    send_item(xrs_pkg::ACT_RANGE, I64_MAX, I64_MAX, '0, 0);
    send_item(xrs_pkg::ACT_RANGE, 64'hfffffffffffffff6, 64'd10, '0, 0);
    send_item(xrs_pkg::ACT_RANGE, 64'd0, I64_MAX, '0, 0);
    send_item(xrs_pkg::ACT_RANGE, 64'd1, 64'd0, '0, 0);
    send_item(ACT_NONE6, rnd64(), rnd64(), rnd64(), 0);
    send_item(ACT_NONE7, rnd64(), rnd64(), rnd64(), 0);
    send_item(xrs_pkg::ACT_SEED, '0, '0, '0, 0);
    send_item(xrs_pkg::ACT_RAW, '0, '0, '0, 0);
    send_item(xrs_pkg::ACT_SEED, '0, '0, 64'hffffffffffffffff, 0);
    send_item(xrs_pkg::ACT_RAW, '0, '0, '0, 0);
    send_item(xrs_pkg::ACT_SEED, '0, '0, 64'h0123456789abcdef, 0);
    send_item(xrs_pkg::ACT_RANGE, 64'hffffffffffffff00, 64'hffffffffffffffff, '0, 0);
    drain();

    // Random phases with different default seeds, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      logic [63:0] s;
      s = (ph == 0) ? 64'd0 : (ph == 1) ? 64'hffffffffffffffff : rnd64();
      write_seed(s); sb.seed_reg = s;
      // long receiver hold-off while the sender keeps offering
      if (ph == 2) stall_hold = 400;
      for (int n = 0; n < 240; n++) begin
        send_random(ph != 2 || n > 20);
        // sender pause until every result is in
        if (ph == 3 && n == 100) while (sb.owed.size() != 0) @(negedge clk);
      end
      drain();
    end

    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
